### rtl/core/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types, register indexes and the letter table of the morse decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

    localparam int MAX_SYMBOLS_DEF  = 5;
    localparam int LETTER_COUNT_DEF = 26;
    localparam int TABLE_SIZE       = 26;

    localparam int PAT_W   = 5;
    localparam int IDX_W   = 3;
    localparam int LEN_W   = 8;
    localparam int CHAR_W  = 7;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0]    DASH_RESET  = 8'd10;
    localparam logic [LEN_W-1:0]    SPACE_RESET = 8'd90;
    localparam logic [LEN_W-1:0]    RUN_MAX     = 8'd255;
    localparam logic [CHAR_W-1:0]   CHAR_BASE   = 7'd97;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DASH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE = 1'b1;

    // bits 4..0 dash positions, bits 7..5 symbol count
    localparam logic [7:0] LETTER_CODES [0:TABLE_SIZE-1] = '{
        8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40, 8'h8E,
        8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62, 8'h60, 8'h21,
        8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83
    };

    typedef struct packed {
        logic key_pressed;
        logic window_end;
    } t_in_item;

    typedef struct packed {
        logic              led_on;
        logic              decoded;
        logic              letter_found;
        logic [CHAR_W-1:0] letter_char;
        logic              space_seen;
    } t_out_item;

endpackage

### rtl/core/mkd_core.sv
// ----------------------------------------------------------------------------
// mkd_core
// Run tracking, dot/dash classification and letter lookup for one item.
// ----------------------------------------------------------------------------
module mkd_core #(
    parameter int MAX_SYMBOLS  = mkd_pkg::MAX_SYMBOLS_DEF,
    parameter int LETTER_COUNT = mkd_pkg::LETTER_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  mkd_pkg::t_in_item                i_item,
    input  logic                             i_cfg_we,
    input  logic [mkd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mkd_pkg::CFG_W-1:0]        i_cfg_data,
    output mkd_pkg::t_out_item               o_result
);
    import mkd_pkg::*;

    logic [LEN_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [PAT_W-1:0] r_pat, n_pat;
    logic [IDX_W-1:0] r_sym, n_sym;
    logic             r_space, n_space;
    logic             r_prior;
    logic [CFG_W-1:0] r_dash_thr, r_space_thr;

    logic [LEN_W-1:0] len_inc;
    logic [LEN_W-1:0] run_len;
    logic             do_class;
    logic [7:0]       code;

    always_comb begin
        len_inc  = (r_len < RUN_MAX) ? r_len + 8'd1 : r_len;
        run_len  = i_item.key_pressed ? len_inc : r_len;
        do_class = (!i_item.key_pressed && r_prior) ||
                   (i_item.window_end && i_item.key_pressed);

        n_len   = i_item.key_pressed ? len_inc : r_len;
        n_idx   = r_idx;
        n_pat   = r_pat;
        n_sym   = r_sym;
        n_space = r_space;

        if (do_class) begin
            if (run_len != '0 && r_idx < IDX_W'(MAX_SYMBOLS)) begin
                if (run_len < r_dash_thr) begin
                    n_sym = r_sym + 3'd1;
                end else if (run_len < r_space_thr) begin
                    n_pat = r_pat | (PAT_W'(1) << r_idx);
                    n_sym = r_sym + 3'd1;
                end else begin
                    n_space = 1'b1;
                end
                n_idx = r_idx + 3'd1;
            end
            n_len = '0;
        end

        code = {n_sym, n_pat};

        o_result              = '0;
        o_result.led_on       = i_item.key_pressed && (len_inc >= r_dash_thr);
        o_result.decoded      = i_item.window_end;
        if (i_item.window_end) begin
            o_result.space_seen = n_space;
            // descending walk so the lowest matching letter wins
            for (int i = LETTER_COUNT - 1; i >= 0; i--) begin
                if (LETTER_CODES[i] == code) begin
                    o_result.letter_found = 1'b1;
                    o_result.letter_char  = CHAR_BASE + CHAR_W'(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_idx       <= '0;
            r_pat       <= '0;
            r_sym       <= '0;
            r_space     <= 1'b0;
            r_prior     <= 1'b0;
            r_dash_thr  <= DASH_RESET;
            r_space_thr <= SPACE_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DASH:  r_dash_thr  <= i_cfg_data;
                    CFG_SPACE: r_space_thr <= i_cfg_data;
                    default:   r_dash_thr  <= r_dash_thr;
                endcase
            end
            if (i_accept) begin
                if (i_item.window_end) begin
                    r_len   <= '0;
                    r_idx   <= '0;
                    r_pat   <= '0;
                    r_sym   <= '0;
                    r_space <= 1'b0;
                    r_prior <= 1'b0;
                end else begin
                    r_len   <= n_len;
                    r_idx   <= n_idx;
                    r_pat   <= n_pat;
                    r_sym   <= n_sym;
                    r_space <= n_space;
                    r_prior <= i_item.key_pressed;
                end
            end
        end
    end

    a_sym_le_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sym <= r_idx) else $error("symbol count exceeds run index");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(MAX_SYMBOLS)) else $error("run index past limit");

    // a nonzero run only exists while the key was held on the previous item
    a_len_prior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) |-> r_prior) else $error("run length without press");

endmodule

### rtl/core/mkd_outbuf.sv
// ----------------------------------------------------------------------------
// mkd_outbuf
// Two-entry output buffer: result register plus skid register.
// ----------------------------------------------------------------------------
module mkd_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mkd_pkg::t_out_item  i_data,
    output logic                o_full,
    output logic                o_valid,
    output mkd_pkg::t_out_item  o_data,
    input  logic                i_stall
);
    import mkd_pkg::*;

    t_out_item r_main, r_skid;
    logic      r_main_v, r_skid_v;
    logic      pop;

    assign pop     = r_main_v && !i_stall;
    assign o_full  = r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || pop) begin
            r_main_v <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_v || pop) begin
            r_main <= r_skid_v ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v) else $error("skid holds item ahead of main");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_v && i_stall && i_push) |=> r_skid_v)
        else $error("item lost while output stalled");

endmodule

### rtl/core/morse_key_decoder_unit.sv
// ----------------------------------------------------------------------------
// morse_key_decoder_unit
// Morse key decoder: classifies press runs and looks up a letter per window.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
//  one item per cycle unless o_in_stall is high; its result is registered in main or skid
//  state update and table match sit between the item input and the result register
//  synchronous active-low reset: thresholds 10 and 90, run state cleared
//  a skid register keeps input open for one item while the output is stalled
// ----------------------------------------------------------------------------
module morse_key_decoder_unit #(
    parameter int MAX_SYMBOLS  = mkd_pkg::MAX_SYMBOLS_DEF,
    parameter int LETTER_COUNT = mkd_pkg::LETTER_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  mkd_pkg::t_in_item                i_in_data,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output mkd_pkg::t_out_item               o_out_data,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_we,
    input  logic [mkd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mkd_pkg::CFG_W-1:0]        i_cfg_data
);
    import mkd_pkg::*;

    logic      accept;
    logic      full;
    t_out_item result;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    mkd_core #(
        .MAX_SYMBOLS  (MAX_SYMBOLS),
        .LETTER_COUNT (LETTER_COUNT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    mkd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

### verif/morse_key_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// morse_key_decoder_unit_tb
// Self-checking bench for the morse key decoder. A short table of directed
// key sequences is followed by random press runs shaped around the current
// thresholds. The bench holds its own model of the run classification and
// the letter lookup, and every output item is compared field by field.
// ----------------------------------------------------------------------------
module morse_key_decoder_unit_tb;

    import mkd_pkg::*;

    localparam int          LETTERS     = 26;
    localparam int          SYMBOL_MAX  = 5;
    localparam logic [6:0]  CHAR_A      = 7'h61;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          PHASES      = 9;

    typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        t_in_item               item;
        logic                   fixed;
        t_out_item              res;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       val;
    } t_stim_row;

    typedef enum logic [1:0] {
        STALL_NONE, STALL_RANDOM, STALL_BURST, STALL_PERIODIC
    } t_stall_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    t_in_item               i_in_data   = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_out_item              o_out_data;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [CFG_W-1:0]       i_cfg_data  = '0;

    morse_key_decoder_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // decoder model state
    logic [7:0] dash_thr;
    logic [7:0] space_thr;
    logic [7:0] run_len;
    logic [2:0] run_pos;
    logic [4:0] dash_mask;
    logic [2:0] sym_cnt;
    logic       space_hit;
    logic       key_was_down;
    logic [7:0] letter_code [0:LETTERS-1];

    t_out_item  pending_results [$];
    t_stim_row  directed_rows [$];

    int errors       = 0;
    int items_in     = 0;
    int results_out  = 0;
    int windows      = 0;
    int letters_hit  = 0;
    int space_windows = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;

    function automatic string morse_of(input int n);
        case (n)
            0:  return ".-";    1:  return "-...";  2:  return "-.-.";
            3:  return "-..";   4:  return ".";     5:  return "..-.";
            6:  return "--.";   7:  return "....";  8:  return "..";
            9:  return ".---";  10: return "-.-";   11: return ".-..";
            12: return "--";    13: return "-.";    14: return "---";
            15: return ".--.";  16: return "--.-";  17: return ".-.";
            18: return "...";   19: return "-";     20: return "..-";
            21: return "...-";  22: return ".--";   23: return "-..-";
            24: return "-.--";  default: return "--..";
        endcase
    endfunction

    function automatic t_out_item res_of(input logic led, input logic dec,
                                         input logic found, input logic [6:0] ch,
                                         input logic sp);
        t_out_item r;
        r.led_on       = led;
        r.decoded      = dec;
        r.letter_found = found;
        r.letter_char  = ch;
        r.space_seen   = sp;
        return r;
    endfunction

    task automatic clear_window();
        run_len      = '0;
        run_pos      = '0;
        dash_mask    = '0;
        sym_cnt      = '0;
        space_hit    = 1'b0;
        key_was_down = 1'b0;
    endtask

    task automatic close_run();
        if (run_len != 0 && run_pos < SYMBOL_MAX) begin
            if (run_len < dash_thr) begin
                sym_cnt = sym_cnt + 3'd1;
            end else if (run_len < space_thr) begin
                dash_mask[run_pos] = 1'b1;
                sym_cnt = sym_cnt + 3'd1;
            end else begin
                space_hit = 1'b1;
            end
            run_pos = run_pos + 3'd1;
        end
        run_len = '0;
    endtask

    task automatic decode_sample(input t_in_item it, output t_out_item r);
        logic [7:0] code;
        r = '0;
        if (it.key_pressed) begin
            if (run_len != 8'hFF)
                run_len = run_len + 8'd1;
            r.led_on = (run_len >= dash_thr);
        end else if (key_was_down) begin
            close_run();
        end
        key_was_down = it.key_pressed;
        if (it.window_end) begin
            if (it.key_pressed)
                close_run();
            code = {sym_cnt, dash_mask};
            r.decoded = 1'b1;
            for (int k = LETTERS - 1; k >= 0; k--) begin
                if (letter_code[k] == code) begin
                    r.letter_found = 1'b1;
                    r.letter_char  = CHAR_A + 7'(k);
                end
            end
            r.space_seen = space_hit;
            clear_window();
        end
    endtask

    task automatic send_item(input t_in_item it, input logic fixed, input t_out_item fixed_res);
        t_out_item r;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                      : $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do
            @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall));
        decode_sample(it, r);
        pending_results.push_back(fixed ? fixed_res : r);
        items_in++;
    endtask

    // only while idle: every expected result has come back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_DASH)
            dash_thr = val;
        else
            space_thr = val;
    endtask

    function automatic int pick_len(input logic long_ok);
        int kind;
        int lo;
        int hi;
        kind = $urandom_range(0, 99);
        if (long_ok && kind < 50)
            return $urandom_range(256, 270);
        if (kind < 40) begin
            hi = (dash_thr > 1) ? dash_thr - 1 : 1;
            return $urandom_range(1, (hi > 16) ? 16 : hi);
        end
        if (kind < 80) begin
            lo = (dash_thr > 0) ? dash_thr : 1;
            hi = (space_thr > 0) ? space_thr - 1 : 0;
            if (hi > lo + 15)
                hi = lo + 15;
            return (hi < lo) ? lo : $urandom_range(lo, hi);
        end
        if (kind < 90) begin
            lo = (space_thr > 0) ? space_thr : 1;
            return lo + $urandom_range(0, 2);
        end
        return $urandom_range(1, 12);
    endfunction

    // one listening window: zero to six press runs, ended on a release or mid-press,
    // or a random item mix; long windows hold a single run so the item count stays modest
    task automatic send_word(input logic long_ok);
        t_in_item q [$];
        t_in_item it;
        int nruns;
        int len;
        logic end_pressed;
        if (!long_ok && $urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 20)) begin
                it.key_pressed = 1'($urandom_range(0, 1));
                it.window_end  = ($urandom_range(0, 9) == 0);
                q.push_back(it);
            end
        end else begin
            nruns = long_ok ? 1 : $urandom_range(0, 6);
            end_pressed = (nruns > 0) && ($urandom_range(0, 2) == 0);
            for (int k = 0; k < nruns; k++) begin
                len = pick_len(long_ok);
                it = '0;
                it.key_pressed = 1'b1;
                repeat (len) q.push_back(it);
                if (!(end_pressed && k == nruns - 1)) begin
                    it.key_pressed = 1'b0;
                    repeat ($urandom_range(1, 3)) q.push_back(it);
                end
            end
            if (end_pressed) begin
                it = q.pop_back();
            end else begin
                it = '0;
            end
            it.window_end = 1'b1;
            q.push_back(it);
        end
        foreach (q[k])
            send_item(q[k], 1'b0, '0);
    endtask

    function automatic logic [15:0] phase_setting(input int p);
        logic [7:0] d;
        case (p)
            0: return {8'd2, 8'd4};
            1: return {8'd3, 8'd8};
            2: return {8'd1, 8'd1};
            3: return {8'd0, 8'd5};
            4: return {8'd6, 8'd3};     // dash not below space
            5: return {8'd255, 8'd255};
            6: return {DASH_RESET, SPACE_RESET};
            7: return {8'd4, 8'd0};
            default: begin
                d = 8'($urandom_range(1, 12));
                return {d, d + 8'($urandom_range(1, 10))};
            end
        endcase
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // output monitor
    t_out_item want_res;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_out++;
            if (o_out_data.decoded) begin
                windows++;
                letters_hit   += o_out_data.letter_found;
                space_windows += o_out_data.space_seen;
            end
            if (pending_results.size() == 0) begin
                errors++;
                $error("output item with nothing expected: %h", o_out_data);
            end else begin
                want_res = pending_results.pop_front();
                check_field("led_on", want_res.led_on, o_out_data.led_on);
                check_field("decoded", want_res.decoded, o_out_data.decoded);
                check_field("letter_found", want_res.letter_found, o_out_data.letter_found);
                check_field("letter_char", want_res.letter_char, o_out_data.letter_char);
                check_field("space_seen", want_res.space_seen, o_out_data.space_seen);
            end
        end
    end

    // receiver backpressure
    t_stall_mode stall_mode = STALL_NONE;
    int stall_span = 0;
    int stall_hold = 0;
    logic stall_lvl = 1'b0;
    int stall_tick = 0;
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_span = $urandom_range(20, 80);
        end
        stall_span--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_RANDOM:   i_out_stall <= ($urandom_range(0, 99) < 30);
            STALL_BURST: begin
                if (stall_hold == 0) begin
                    stall_hold = $urandom_range(1, 8);
                    stall_lvl  = ~stall_lvl;
                end
                stall_hold--;
                i_out_stall <= stall_lvl;
            end
            default:        i_out_stall <= (stall_tick % 3 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("morse_key_decoder_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row   row;
        logic [15:0] setting;
        int          budget;
        int          start_items;
        string       m;

        for (int k = 0; k < LETTERS; k++) begin
            m = morse_of(k);
            letter_code[k] = {3'(m.len()), 5'b0};
            for (int b = 0; b < m.len(); b++)
                if (m[b] == "-")
                    letter_code[k][b] = 1'b1;
        end
        dash_thr  = DASH_RESET;
        space_thr = SPACE_RESET;
        clear_window();

        // directed table
        row = '0;
        row.kind = ROW_ITEM;
        // empty window right after reset: no letter
        row.item = 2'b01; row.fixed = 1'b1;
        row.res = res_of(1'b0, 1'b1, 1'b0, 7'd0, 1'b0);
        directed_rows.push_back(row);
        // single tick press ending the window: dot, letter e
        row.item = 2'b11; row.res = res_of(1'b0, 1'b1, 1'b1, 7'd101, 1'b0);
        directed_rows.push_back(row);
        row = '0; row.kind = ROW_CFG; row.idx = CFG_DASH;  row.val = 8'd2;
        directed_rows.push_back(row);
        row.idx = CFG_SPACE; row.val = 8'd4;
        directed_rows.push_back(row);
        // dot then dash, window ends on release: letter a
        row = '0; row.kind = ROW_ITEM;
        row.item = 2'b10; directed_rows.push_back(row);
        row.item = 2'b00; directed_rows.push_back(row);
        row.item = 2'b10; directed_rows.push_back(row);
        directed_rows.push_back(row);
        row.item = 2'b00; directed_rows.push_back(row);
        row.item = 2'b01; row.fixed = 1'b1;
        row.res = res_of(1'b0, 1'b1, 1'b1, 7'd97, 1'b0);
        directed_rows.push_back(row);
        // space run takes a position, then a dot
        row = '0; row.kind = ROW_ITEM; row.item = 2'b10;
        repeat (4) directed_rows.push_back(row);
        row.item = 2'b00; directed_rows.push_back(row);
        row.item = 2'b11; row.fixed = 1'b1;
        row.res = res_of(1'b0, 1'b1, 1'b1, 7'd101, 1'b1);
        directed_rows.push_back(row);
        // five dots, then a sixth run that is ignored: no letter
        row = '0; row.kind = ROW_ITEM;
        repeat (5) begin
            row.item = 2'b10; directed_rows.push_back(row);
            row.item = 2'b00; directed_rows.push_back(row);
        end
        row.item = 2'b10; directed_rows.push_back(row);
        row.item = 2'b11; row.fixed = 1'b1;
        row.res = res_of(1'b1, 1'b1, 1'b0, 7'd0, 1'b0);
        directed_rows.push_back(row);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG)
                write_reg(directed_rows[k].idx, directed_rows[k].val);
            else
                send_item(directed_rows[k].item, directed_rows[k].fixed,
                          directed_rows[k].res);
        end

        // random phases, each on a new pair of thresholds
        for (int p = 0; p < PHASES; p++) begin
            setting = phase_setting(p);
            write_reg(CFG_DASH, setting[15:8]);
            write_reg(CFG_SPACE, setting[7:0]);
            budget = (p == 5) ? 1 : (p == 6) ? 60 : 40;
            start_items = items_in;
            while (items_in - start_items < budget)
                send_word(p == 5);
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d input items and %0d results over %0d threshold settings",
                 items_in, results_out, PHASES + 2);
        $display("%0d windows decoded, %0d letters found, %0d with a space run",
                 windows, letters_hit, space_windows);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("morse_key_decoder_unit regression: pass");
        end else begin
            $display("morse_key_decoder_unit regression: fail");
        end
        $finish;
    end

endmodule
